// ===== rtl/core/sequenced_overwrite_ring_top_assert.svh =====
// Assertion macros for the notification ring.
`ifndef SEQUENCED_OVERWRITE_RING_TOP_ASSERT_SVH
`define SEQUENCED_OVERWRITE_RING_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SOR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sor assertion failed");

// Next-cycle implication, disabled during reset.
`define SOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sor assertion failed");

`endif

// ===== rtl/core/sor_pkg.sv =====
package sor_pkg;

    localparam int RING_DEPTH_DEF   = 64;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int SEQ_BITS         = 64;
    localparam int DATA_BITS        = 64;
    localparam int CFG_ADDR_BITS    = 3;
    localparam int CFG_DATA_BITS    = 32;

    localparam logic OP_PUBLISH = 1'b0;
    localparam logic OP_LISTEN  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    localparam logic [CFG_ADDR_BITS-1:0] ADDR_SHUT_DOWN = 3'd0;

    typedef struct packed {
        logic                 operation;
        logic [DATA_BITS-1:0] payload_in;
    } req_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [DATA_BITS-1:0] payload_out;
    } rsp_t;

endpackage

// ===== rtl/core/sor_ram.sv =====
module sor_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/sequenced_overwrite_ring_top.sv =====
// Single-reader notification ring that overwrites its oldest entries.
// Request channel (req_valid/req_stall/req): operation 0 publishes payload_in
// under the next write sequence, operation 1 makes one non-blocking read.
// Response channel (rsp_valid/rsp_stall/rsp): exactly one beat per request,
// in order; status 0 done/delivered, 1 nothing new, 2 refused. payload_out
// carries the delivered notification, zero otherwise.
// A response passes through the payload RAM read stage (stage one) and
// then the output register before it appears.
// Throughput: one request per cycle while req_stall is low; the sequence
// counters update at accept, and the RAM is read or written at most once per request.
// When the receiver stalls, the output register holds its beat, one more
// request is kept in the RAM-read stage, and then req_stall rises.
// Reset: both sequences return to one, shut_down clears, the ring reads as
// empty at once. Payload entries are not cleared, no clearing pass.
// Config: APB register shut_down at address 0; when set, every request is
// answered with status 2 and changes nothing. Write only while idle.
module sequenced_overwrite_ring_top #(
    parameter int RING_DEPTH   = sor_pkg::RING_DEPTH_DEF,
    parameter int PAYLOAD_BITS = sor_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  sor_pkg::req_t                     req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output sor_pkg::rsp_t                     rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sor_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [sor_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [sor_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    import sor_pkg::*;

    `include "sequenced_overwrite_ring_top_assert.svh"

    localparam int SLOT_BITS = $clog2(RING_DEPTH);
    localparam logic [SEQ_BITS-1:0]  DEPTH_SEQ  = SEQ_BITS'(RING_DEPTH);
    localparam logic [SEQ_BITS-1:0]  DEPTH_M1   = SEQ_BITS'(RING_DEPTH - 1);
    localparam logic [SLOT_BITS-1:0] SLOT_LAST  = SLOT_BITS'(RING_DEPTH - 1);
    localparam logic [SLOT_BITS-1:0] SLOT_ONE   = SLOT_BITS'(1);
    localparam logic [SEQ_BITS-1:0]  SEQ_ONE    = SEQ_BITS'(1);

    logic                 shut_down_reg;
    logic [SEQ_BITS-1:0]  wr_seq_reg, wr_seq_next;
    logic [SEQ_BITS-1:0]  rd_seq_reg, rd_seq_next;
    logic [SEQ_BITS-1:0]  oldest_reg, oldest_next;
    logic [SLOT_BITS-1:0] wr_slot_reg, wr_slot_next;
    logic [SLOT_BITS-1:0] rd_slot_reg, rd_slot_next;

    logic                 s1_valid_reg;
    logic [1:0]           s1_status_reg, s1_status_next;
    logic                 s1_hit_reg, s1_hit_next;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg, rsp_next;

    logic                    req_accept, s1_adv, cfg_write;
    logic                    lag, avail, pub_ok, ram_we, ram_re;
    logic [SEQ_BITS-1:0]     rd_eff;
    logic [SLOT_BITS-1:0]    rd_slot_eff;
    logic [PAYLOAD_BITS-1:0] ram_rdata;
    logic [DATA_BITS-1:0]    rdata_ext;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign prdata     = (paddr == ADDR_SHUT_DOWN) ? {{(CFG_DATA_BITS-1){1'b0}}, shut_down_reg}
                                                  : '0;

    assign s1_adv     = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = s1_valid_reg && !s1_adv;
    assign req_accept = req_valid && !req_stall;

    assign lag         = rd_seq_reg < oldest_reg;
    assign rd_eff      = lag ? oldest_reg : rd_seq_reg;
    assign rd_slot_eff = lag ? wr_slot_reg : rd_slot_reg;
    assign avail       = rd_eff != wr_seq_reg;
    assign pub_ok      = wr_seq_reg != '1;

    assign ram_we = req_accept && !shut_down_reg && (req.operation == OP_PUBLISH) && pub_ok;
    assign ram_re = req_accept && !shut_down_reg && (req.operation == OP_LISTEN) && avail;

    always_comb
    begin
        wr_seq_next    = wr_seq_reg;
        oldest_next    = oldest_reg;
        wr_slot_next   = wr_slot_reg;
        rd_seq_next    = rd_seq_reg;
        rd_slot_next   = rd_slot_reg;
        s1_status_next = ST_REFUSED;
        s1_hit_next    = 1'b0;
        if (!shut_down_reg)
        begin
            if (req.operation == OP_PUBLISH)
            begin
                if (pub_ok)
                begin
                    s1_status_next = ST_OK;
                    wr_seq_next    = wr_seq_reg + SEQ_ONE;
                    oldest_next    = (wr_seq_reg >= DEPTH_SEQ) ? wr_seq_reg - DEPTH_M1 : SEQ_ONE;
                    wr_slot_next   = (wr_slot_reg == SLOT_LAST) ? '0 : wr_slot_reg + SLOT_ONE;
                end
            end
            else
            begin
                s1_status_next = ST_EMPTY;
                rd_seq_next    = rd_eff;
                rd_slot_next   = rd_slot_eff;
                if (avail)
                begin
                    s1_status_next = ST_OK;
                    s1_hit_next    = 1'b1;
                    rd_seq_next    = rd_eff + SEQ_ONE;
                    rd_slot_next   = (rd_slot_eff == SLOT_LAST) ? '0 : rd_slot_eff + SLOT_ONE;
                end
            end
        end
    end

    always_comb
    begin
        rdata_ext                   = '0;
        rdata_ext[PAYLOAD_BITS-1:0] = ram_rdata;
        rsp_next.status             = s1_status_reg;
        rsp_next.payload_out        = s1_hit_reg ? rdata_ext : '0;
    end

    sor_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (RING_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_slot_reg),
        .wdata (req.payload_in[PAYLOAD_BITS-1:0]),
        .re    (ram_re),
        .raddr (rd_slot_eff),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shut_down_reg <= 1'b0;
            wr_seq_reg    <= SEQ_ONE;
            rd_seq_reg    <= SEQ_ONE;
            oldest_reg    <= SEQ_ONE;
            wr_slot_reg   <= SLOT_ONE;
            rd_slot_reg   <= SLOT_ONE;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr == ADDR_SHUT_DOWN))
            begin
                shut_down_reg <= pwdata[0];
            end
            if (req_accept)
            begin
                wr_seq_reg  <= wr_seq_next;
                rd_seq_reg  <= rd_seq_next;
                oldest_reg  <= oldest_next;
                wr_slot_reg <= wr_slot_next;
                rd_slot_reg <= rd_slot_next;
            end
            if (req_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_status_reg <= s1_status_next;
            s1_hit_reg    <= s1_hit_next;
        end
        if (s1_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // read pointer never passes the write pointer
    `SOR_ASSERT_NOW(a_rd_le_wr, clk, rst_n, 1'b1, rd_seq_reg <= wr_seq_reg)
    // accepted good publish advances the write sequence by one
    `SOR_ASSERT_NEXT(a_wr_step, clk, rst_n, ram_we, wr_seq_reg == $past(wr_seq_reg) + SEQ_ONE)
    // RAM read data must hold while its beat waits in stage one
    `SOR_ASSERT_NEXT(a_rdata_hold, clk, rst_n, s1_valid_reg && !s1_adv, $stable(ram_rdata))
    // a hit always reports delivered
    `SOR_ASSERT_NOW(a_hit_ok, clk, rst_n, s1_valid_reg && s1_hit_reg, s1_status_reg == ST_OK)

endmodule

// ===== verif/tb_sequenced_overwrite_ring_top.sv =====
module tb_sequenced_overwrite_ring_top;
    import sor_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEM_TARGET   = 1250;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [DATA_BITS-1:0] PAYLOAD_MASK =
        {DATA_BITS{1'b1}} >> (DATA_BITS - PAYLOAD_BITS_DEF);

    class ring_scoreboard;
        logic [SEQ_BITS-1:0]  wr_seq;
        logic [SEQ_BITS-1:0]  rd_seq;
        logic [SEQ_BITS-1:0]  slot_seq [RING_DEPTH_DEF];
        logic [DATA_BITS-1:0] slot_data [RING_DEPTH_DEF];
        logic                 shut_down;
        rsp_t                 expected_rsp [$];
        int                   mismatches;

        function new();
            wr_seq     = 1;
            rd_seq     = 1;
            shut_down  = 1'b0;
            mismatches = 0;
            foreach (slot_seq[i])
            begin
                slot_seq[i]  = '0;
                slot_data[i] = '0;
            end
        endfunction

        function void note_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR @%0t: %s", $time, msg);
        endfunction

        // ring update for one accepted request beat
        function void predict_request(req_t r);
            rsp_t                want;
            logic [SEQ_BITS-1:0] oldest;
            int                  idx;
            want.status      = ST_REFUSED;
            want.payload_out = '0;
            if (!shut_down)
            begin
                if (r.operation == OP_PUBLISH)
                begin
                    if (wr_seq != {SEQ_BITS{1'b1}})
                    begin
                        idx            = int'(wr_seq % RING_DEPTH_DEF);
                        slot_data[idx] = r.payload_in & PAYLOAD_MASK;
                        slot_seq[idx]  = wr_seq;
                        wr_seq         = wr_seq + 1;
                        want.status    = ST_OK;
                    end
                end
                else
                begin
                    oldest = (wr_seq > RING_DEPTH_DEF) ? wr_seq - RING_DEPTH_DEF : 1;
                    if (rd_seq < oldest)
                        rd_seq = oldest;
                    want.status = ST_EMPTY;
                    if (rd_seq < wr_seq)
                    begin
                        idx = int'(rd_seq % RING_DEPTH_DEF);
                        if (slot_seq[idx] == rd_seq)
                        begin
                            want.payload_out = slot_data[idx];
                            want.status      = ST_OK;
                            rd_seq           = rd_seq + 1;
                        end
                    end
                end
            end
            expected_rsp.push_back(want);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                note_error($sformatf("unexpected beat status %0d payload %h",
                                     got.status, got.payload_out));
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status)
                note_error($sformatf("status expected %0d got %0d",
                                     want.status, got.status));
            if (got.payload_out !== want.payload_out)
                note_error($sformatf("payload_out expected %h got %h",
                                     want.payload_out, got.payload_out));
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_stall;
    req_t                     req       = '0;
    logic                     rsp_valid;
    logic                     rsp_stall = 1'b0;
    rsp_t                     rsp;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr     = '0;
    logic [CFG_DATA_BITS-1:0] pwdata    = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    ring_scoreboard sb = new();
    int  issued  = 0;
    int  cycles  = 0;
    int  rx_hold = 0;
    int  rx_left = 0;
    bit  tx_gaps = 1'b0;

    sequenced_overwrite_ring_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sequenced_overwrite_ring_top verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.predict_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    // receiver: long hold-off first, else alternating free and stalled runs
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rsp_stall = 1'b1;
            rx_hold--;
        end
        else
        begin
            if (rx_left == 0)
            begin
                if (rsp_stall)
                begin
                    rsp_stall = 1'b0;
                    rx_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 8);
                end
                else
                begin
                    rsp_stall = 1'b1;
                    rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                          : $urandom_range(1, 3);
                end
            end
            rx_left--;
        end
    end

    function automatic logic [DATA_BITS-1:0] rand_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic int sender_gap();
        int pick;
        if (!tx_gaps)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    task automatic send_beat(logic op, logic [DATA_BITS-1:0] data);
        @(negedge clk);
        req_valid         = 1'b1;
        req.operation     = op;
        req.payload_in    = data;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        issued++;
    endtask

    task automatic pause_sender(int n);
        if (n > 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic offer(logic op, logic [DATA_BITS-1:0] data);
        send_beat(op, data);
        pause_sender(sender_gap());
    endtask

    task automatic drain();
        pause_sender(1);
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_shut_down(logic value);
        drain();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_SHUT_DOWN;
        pwdata  = {{(CFG_DATA_BITS-1){1'b0}}, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.shut_down = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial
    begin
        int kind;
        int n;
        int next_phase;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_shut_down(1'b0);

        // directed: empty read, payload extremes, catch-up to empty, refusal
        offer(OP_LISTEN, '1);
        offer(OP_PUBLISH, '0);
        offer(OP_PUBLISH, '1);
        offer(OP_PUBLISH, 64'haaaa_aaaa_aaaa_aaaa);
        offer(OP_PUBLISH, 64'h5555_5555_5555_5555);
        offer(OP_PUBLISH, 64'h0123_4567_89ab_cdef);
        repeat (6) offer(OP_LISTEN, '0);
        write_shut_down(1'b1);
        offer(OP_PUBLISH, '1);
        offer(OP_LISTEN, '1);
        write_shut_down(1'b0);
        offer(OP_LISTEN, 64'h8000_0000_0000_0001);

        // back-pressure: receiver holds off while publishes keep coming
        drain();
        rx_hold = 150;
        repeat (24) offer(OP_PUBLISH, rand_word());
        repeat (8) offer(OP_LISTEN, rand_word());
        drain();

        next_phase = issued + 300;
        while (issued < ITEM_TARGET)
        begin
            if (issued >= next_phase)
            begin
                write_shut_down(1'b1);
                n = $urandom_range(3, 6);
                repeat (n) offer(logic'($urandom_range(0, 1)), rand_word());
                write_shut_down(1'b0);
                next_phase = issued + 300;
            end
            tx_gaps = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                n = $urandom_range(1, 8);
                repeat (n) offer(OP_PUBLISH, rand_word());
                n = $urandom_range(1, 10);
                repeat (n) offer(OP_LISTEN, rand_word());
            end
            else if (kind < 60)
            begin
                // overrun the ring so the reader must skip to the oldest entry
                n = $urandom_range(60, 80);
                repeat (n) offer(OP_PUBLISH, rand_word());
                n = $urandom_range(1, 6);
                repeat (n) offer(OP_LISTEN, rand_word());
            end
            else if (kind < 90)
            begin
                n = $urandom_range(1, 10);
                repeat (n) offer(logic'($urandom_range(0, 1)), rand_word());
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) offer(OP_LISTEN, rand_word());
            end
        end

        drain();
        if (sb.expected_rsp.size() != 0)
            sb.note_error($sformatf("%0d beats never arrived", sb.expected_rsp.size()));
        if (sb.mismatches == 0)
            $display("sequenced_overwrite_ring_top verification clean");
        else
            $display("sequenced_overwrite_ring_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sor_pkg.sv
rtl/core/sor_ram.sv
rtl/core/sequenced_overwrite_ring_top.sv
verif/tb_sequenced_overwrite_ring_top.sv
